// ===== hw/rtl/pfrg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfrg_pkg
// Shared types and constants of the packet FIFO with resource block grant.
// ----------------------------------------------------------------------------
package pfrg_pkg;

    localparam int ID_W    = 16;
    localparam int BYTES_W = 16;
    localparam int BPB_W   = 16;
    localparam int BLK_W   = 10;
    localparam int CAP_W   = BPB_W + BLK_W;
    localparam int QLEN_W  = 7;
    localparam int QBYTE_W = 22;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_GRANT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DROP  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic [CAP_W-1:0]   cap;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic               last;
        logic [QLEN_W-1:0]  qlen;
        logic [QBYTE_W-1:0] qbytes;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/pfrg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfrg_front
// Input stage: takes a command transfer, forms the grant byte capacity and
// pushes the classified command into the command queue.
// ----------------------------------------------------------------------------
module pfrg_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [1:0]             i_command,
    input  wire logic [15:0]            i_packet_id,
    input  wire logic [15:0]            i_packet_bytes,
    input  wire logic [15:0]            i_bytes_per_block,
    input  wire logic [9:0]             i_blocks_available,
    output logic                        o_push,
    input  wire logic                   i_push_ready,
    output pfrg_pkg::t_cmd              o_cmd
);
    import pfrg_pkg::*;

    logic               r_fv;
    logic               n_fv;
    t_op                r_op;
    logic [ID_W-1:0]    r_id;
    logic [BYTES_W-1:0] r_bytes;
    logic [BPB_W-1:0]   r_bpb;
    logic [BLK_W-1:0]   r_blk;
    logic               w_take;

    assign o_ready = !r_fv || i_push_ready;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_fv;

    always_comb begin
        o_cmd.op    = r_op;
        o_cmd.id    = r_id;
        o_cmd.bytes = r_bytes;
        o_cmd.cap   = CAP_W'(r_blk) * CAP_W'(r_bpb);
    end

    always_comb begin
        n_fv = r_fv;
        if (w_take) begin
            n_fv = 1'b1;
        end else if (i_push_ready) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op    <= t_op'(i_command);
            r_id    <= i_packet_id;
            r_bytes <= i_packet_bytes;
            r_bpb   <= i_bytes_per_block;
            r_blk   <= i_blocks_available;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pfrg_cmd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfrg_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module pfrg_cmd_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    output logic                        o_push_ready,
    input  wire pfrg_pkg::t_cmd         i_cmd,
    output logic                        o_valid,
    input  wire logic                   i_pop,
    output pfrg_pkg::t_cmd              o_cmd
);
    import pfrg_pkg::*;

    t_cmd       r_data [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_cmd        = r_data[r_rp];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_data[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pfrg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfrg_back
// Execution stage: descriptor memory, pointers, totals, grant loop and the
// result register.
// ----------------------------------------------------------------------------
module pfrg_back #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    output logic                        o_q_pop,
    input  wire pfrg_pkg::t_cmd         i_cmd,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output pfrg_pkg::t_result           o_res
);
    import pfrg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + BYTES_W + 1;
    localparam int CMP_W = (SUM_W > CAP_W) ? SUM_W : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    logic [ID_W-1:0]    mem_id    [QUEUE_DEPTH];
    logic [BYTES_W-1:0] mem_bytes [QUEUE_DEPTH];

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [QBYTE_W-1:0] r_total, n_total;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_pend_valid, n_pend_valid;
    t_result            r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;
    logic [ID_W-1:0]    r_rd_id;
    logic [BYTES_W-1:0] r_rd_bytes;

    logic               w_we;
    logic               w_emit;
    logic               w_out_free;
    logic               w_fits;
    logic [SUM_W-1:0]   w_sum_next;
    logic [PTR_W-1:0]   w_head_inc;
    logic [PTR_W-1:0]   w_tail_inc;
    logic [CNT_W-1:0]   w_cnt_dn;
    logic [QBYTE_W-1:0] w_tot_dn;

    function automatic t_result mk_res(t_status st, logic [ID_W-1:0] id,
                                       logic [BYTES_W-1:0] by, logic lst,
                                       logic [CNT_W-1:0] cnt,
                                       logic [QBYTE_W-1:0] tot);
        t_result res;
        res.status = st;
        res.id     = id;
        res.bytes  = by;
        res.last   = lst;
        res.qlen   = QLEN_W'(cnt);
        res.qbytes = tot;
        return res;
    endfunction

    assign o_valid    = r_out_valid;
    assign o_res      = r_out;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_head_inc = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_inc = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign w_cnt_dn   = r_count - 1'b1;
    assign w_tot_dn   = r_total - QBYTE_W'(r_rd_bytes);
    assign w_sum_next = r_sum + SUM_W'(r_rd_bytes);
    assign w_fits     = (r_count != '0) && (CMP_W'(w_sum_next) <= CMP_W'(r_cmd.cap));

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_total      = r_total;
        n_sum        = r_sum;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_out;
        w_we         = 1'b0;
        w_emit       = 1'b0;
        o_q_pop      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop      = 1'b1;
                    n_cmd        = i_cmd;
                    n_sum        = '0;
                    n_pend_valid = 1'b0;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    case (r_cmd.op)
                        OP_ENQ: begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_out = mk_res(ST_DROP, r_cmd.id, r_cmd.bytes, 1'b1,
                                               r_count, r_total);
                            end else begin
                                w_we    = 1'b1;
                                n_tail  = w_tail_inc;
                                n_count = r_count + 1'b1;
                                n_total = r_total + QBYTE_W'(r_cmd.bytes);
                                n_out   = mk_res(ST_OK, r_cmd.id, r_cmd.bytes, 1'b1,
                                                 n_count, n_total);
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (r_count == '0) begin
                                n_out = mk_res(ST_EMPTY, '0, '0, 1'b1, r_count, r_total);
                            end else begin
                                if (r_cmd.op == OP_DEQ) begin
                                    n_head  = w_head_inc;
                                    n_count = w_cnt_dn;
                                    n_total = w_tot_dn;
                                end
                                n_out = mk_res(ST_OK, r_rd_id, r_rd_bytes, 1'b1,
                                               n_count, n_total);
                            end
                        end
                        OP_GRANT: begin
                            if (w_fits) begin
                                if (r_pend_valid) begin
                                    w_emit = 1'b1;
                                    n_out  = r_pend;
                                end
                                n_head       = w_head_inc;
                                n_count      = w_cnt_dn;
                                n_total      = w_tot_dn;
                                n_sum        = w_sum_next;
                                n_pend_valid = 1'b1;
                                n_pend       = mk_res(ST_OK, r_rd_id, r_rd_bytes, 1'b0,
                                                      w_cnt_dn, w_tot_dn);
                            end else begin
                                w_emit  = 1'b1;
                                n_state = S_IDLE;
                                if (r_pend_valid) begin
                                    n_out      = r_pend;
                                    n_out.last = 1'b1;
                                end else begin
                                    n_out = mk_res(ST_EMPTY, '0, '0, 1'b1, r_count,
                                                   r_total);
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_total      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_total      <= n_total;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_sum <= n_sum;
        r_pend <= n_pend;
        r_out <= n_out;
    end

    // descriptor memory, read port follows the next head
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_id[r_tail]    <= r_cmd.id;
            mem_bytes[r_tail] <= r_cmd.bytes;
        end
        r_rd_id    <= mem_id[n_head];
        r_rd_bytes <= mem_bytes[n_head];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/packet_fifo_with_rb_grant.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// packet_fifo_with_rb_grant
// Packet descriptor FIFO with enqueue, dequeue, peek and resource block grant.
// ----------------------------------------------------------------------------
// Commands pass an input register (where the grant capacity is multiplied
// out) and a two-entry command queue before the execution stage, so new
// commands are taken while earlier ones still run. The execution stage is a
// two-state sequencer around the descriptor memory: enqueue, dequeue and peek
// take a load step and an execute step each; a grant takes a load step, an
// execute step for each granted packet, and a closing step that finds the head
// which does not fit or the empty queue and marks the last result. The memory
// read port is registered and addressed by the next head pointer, which sets
// the one-packet-per-cycle grant rate while the result register is free. A
// full result register stalls the sequencer until the result is taken.
// ----------------------------------------------------------------------------
module packet_fifo_with_rb_grant #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_command,
    input  wire logic [15:0]    i_packet_id,
    input  wire logic [15:0]    i_packet_bytes,
    input  wire logic [15:0]    i_bytes_per_block,
    input  wire logic [9:0]     i_blocks_available,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [1:0]          o_status,
    output logic [15:0]         o_out_id,
    output logic [15:0]         o_out_bytes,
    output logic                o_last,
    output logic [6:0]          o_queue_length,
    output logic [21:0]         o_queue_bytes
);
    import pfrg_pkg::*;

    logic    w_push;
    logic    w_push_ready;
    t_cmd    w_front_cmd;
    logic    w_q_valid;
    logic    w_q_pop;
    t_cmd    w_q_cmd;
    t_result w_res;

    pfrg_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_packet_id        (i_packet_id),
        .i_packet_bytes     (i_packet_bytes),
        .i_bytes_per_block  (i_bytes_per_block),
        .i_blocks_available (i_blocks_available),
        .o_push             (w_push),
        .i_push_ready       (w_push_ready),
        .o_cmd              (w_front_cmd)
    );

    pfrg_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_cmd        (w_front_cmd),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_cmd        (w_q_cmd)
    );

    pfrg_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_cmd     (w_q_cmd),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res)
    );

    assign o_status       = w_res.status;
    assign o_out_id       = w_res.id;
    assign o_out_bytes    = w_res.bytes;
    assign o_last         = w_res.last;
    assign o_queue_length = w_res.qlen;
    assign o_queue_bytes  = w_res.qbytes;

`ifndef SYNTHESIS
    a_drop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DROP) |-> o_last)
        else $error("dropped packet result not marked last");

    a_empty_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_last && o_out_id == '0 && o_out_bytes == '0))
        else $error("empty result carries a packet");

    a_no_pop_without_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("command queue popped while empty");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
